/* design/tbs_pkg.sv */
// shared types and constants for the temperature batch statistics block
// no dependencies; used by every file of the block
`timescale 1ns / 1ps

package tbs_pkg;

  localparam int MaxBatch = 128;

  localparam int SampleW  = 16;
  localparam int LevelW   = 15;
  localparam int CountW   = 8;
  localparam int IndexW   = 7;
  localparam int SumW     = 22;
  localparam int PosW     = $clog2(MaxBatch + 1);
  localparam int CfgIdxW  = 8;
  localparam int DivSteps = SumW;
  localparam int DivCntW  = $clog2(DivSteps);

  localparam logic [SumW-1:0]   SumMax   = '1;
  localparam logic [CountW-1:0] CountMax = '1;
  localparam logic [IndexW-1:0] IndexMax = '1;

  localparam logic [LevelW-1:0] WarningReset  = LevelW'(480);
  localparam logic [LevelW-1:0] CriticalReset = LevelW'(640);
  localparam logic [LevelW-1:0] ShutdownReset = LevelW'(800);
  localparam logic [LevelW-1:0] AlertReset    = LevelW'(720);

  typedef enum logic [CfgIdxW-1:0] {
    REG_WARNING  = 8'd0,
    REG_CRITICAL = 8'd1,
    REG_SHUTDOWN = 8'd2,
    REG_ALERT    = 8'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_ACCUM,
    ST_DIVIDE,
    ST_PUBLISH
  } ctrl_state_e;

  typedef enum logic [1:0] {
    BIN_NORMAL   = 2'd0,
    BIN_WARNING  = 2'd1,
    BIN_CRITICAL = 2'd2,
    BIN_SHUTDOWN = 2'd3
  } bin_e;

  localparam int NumBins = 4;

  typedef struct packed {
    logic accept;
    logic finish;
    logic div_step;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic batch_end;
  } dp_status_t;

  // first field in the lowest bits, so declared last
  typedef struct packed {
    logic [LevelW-1:0] alert_value;
    logic [IndexW-1:0] alert_index;
    logic [CountW-1:0] shutdown_count;
    logic [CountW-1:0] critical_count;
    logic [CountW-1:0] warning_count;
    logic [CountW-1:0] normal_count;
    logic [CountW-1:0] skipped_count;
    logic [CountW-1:0] valid_count;
    logic [LevelW-1:0] average;
    logic [LevelW-1:0] maximum;
    logic [LevelW-1:0] minimum;
  } result_t;

  localparam int ResW   = $bits(result_t);
  localparam int TdataW = ((ResW + 7) / 8) * 8;

endpackage

/* design/tbs_ctrl.sv */
// controller state machine: sample intake, divider sequencing, result handoff
// depends on tbs_pkg
`timescale 1ns / 1ps

module tbs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  tbs_pkg::dp_status_t status_i,
  output tbs_pkg::dp_cmd_t    cmd_o
);

  tbs_pkg::ctrl_state_e          state_q, state_d;
  logic [tbs_pkg::DivCntW-1:0]   cnt_q, cnt_d;
  logic                          out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tbs_pkg::ST_ACCUM;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      tbs_pkg::ST_ACCUM: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        cmd_o.finish = in_valid_i & status_i.batch_end;
        if (cmd_o.finish) begin
          state_d = tbs_pkg::ST_DIVIDE;
          cnt_d   = '0;
        end
      end
      tbs_pkg::ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == tbs_pkg::DivCntW'(tbs_pkg::DivSteps - 1)) begin
          state_d = tbs_pkg::ST_PUBLISH;
        end
      end
      tbs_pkg::ST_PUBLISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = tbs_pkg::ST_ACCUM;
        end
      end
      default: begin
        state_d = tbs_pkg::ST_ACCUM;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* design/tbs_datapath.sv */
// datapath: threshold registers, batch accumulators, batch snapshot,
// restoring divider for the average and the output register; depends on tbs_pkg
`timescale 1ns / 1ps

module tbs_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tbs_pkg::dp_cmd_t                    cmd_i,
  output tbs_pkg::dp_status_t                 status_o,
  input  logic [tbs_pkg::SampleW-1:0]         sample_i,
  input  logic                                last_i,
  input  logic                                cfg_valid_i,
  input  logic [tbs_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [tbs_pkg::LevelW-1:0]          cfg_data_i,
  output tbs_pkg::result_t                    result_o,
  output logic                                alert_found_o
);

  localparam int LevelW = tbs_pkg::LevelW;
  localparam int CountW = tbs_pkg::CountW;
  localparam int SumW   = tbs_pkg::SumW;
  localparam int PosW   = tbs_pkg::PosW;
  localparam int IndexW = tbs_pkg::IndexW;

  // thresholds
  logic [LevelW-1:0] warn_q, crit_q, shut_q, alert_lvl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warn_q      <= tbs_pkg::WarningReset;
      crit_q      <= tbs_pkg::CriticalReset;
      shut_q      <= tbs_pkg::ShutdownReset;
      alert_lvl_q <= tbs_pkg::AlertReset;
    end else if (cfg_valid_i) begin
      case (tbs_pkg::cfg_reg_e'(cfg_index_i))
        tbs_pkg::REG_WARNING:  warn_q      <= cfg_data_i;
        tbs_pkg::REG_CRITICAL: crit_q      <= cfg_data_i;
        tbs_pkg::REG_SHUTDOWN: shut_q      <= cfg_data_i;
        tbs_pkg::REG_ALERT:    alert_lvl_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // batch accumulators
  logic [PosW-1:0]   pos_q;
  logic [SumW-1:0]   sum_q;
  logic [LevelW-1:0] min_q, max_q;
  logic [CountW-1:0] good_q, err_q;
  logic [CountW-1:0] bin_q [tbs_pkg::NumBins];
  logic              hit_q;
  logic [IndexW-1:0] hit_pos_q;
  logic [LevelW-1:0] hit_val_q;

  logic [PosW-1:0]   pos_d;
  logic [SumW-1:0]   sum_d;
  logic [LevelW-1:0] min_d, max_d;
  logic [CountW-1:0] good_d, err_d;
  logic [CountW-1:0] bin_d [tbs_pkg::NumBins];
  logic              hit_d;
  logic [IndexW-1:0] hit_pos_d;
  logic [LevelW-1:0] hit_val_d;

  logic              good_sample;
  logic [LevelW-1:0] s;
  logic [SumW:0]     sum_wide;
  tbs_pkg::bin_e     bin;

  always_comb begin
    good_sample = ~sample_i[tbs_pkg::SampleW-1];
    s           = sample_i[LevelW-1:0];
    sum_wide    = {1'b0, sum_q} + (SumW+1)'(s);

    if (s < warn_q) begin
      bin = tbs_pkg::BIN_NORMAL;
    end else if (s < crit_q) begin
      bin = tbs_pkg::BIN_WARNING;
    end else if (s < shut_q) begin
      bin = tbs_pkg::BIN_CRITICAL;
    end else begin
      bin = tbs_pkg::BIN_SHUTDOWN;
    end

    pos_d     = pos_q + 1'b1;
    sum_d     = sum_q;
    min_d     = min_q;
    max_d     = max_q;
    good_d    = good_q;
    err_d     = err_q;
    hit_d     = hit_q;
    hit_pos_d = hit_pos_q;
    hit_val_d = hit_val_q;
    for (int i = 0; i < tbs_pkg::NumBins; i++) begin
      bin_d[i] = bin_q[i];
    end

    if (!good_sample) begin
      err_d = (err_q == tbs_pkg::CountMax) ? err_q : err_q + 1'b1;
    end else begin
      min_d  = (good_q == '0 || s < min_q) ? s : min_q;
      max_d  = (good_q == '0 || s > max_q) ? s : max_q;
      sum_d  = (sum_wide > {1'b0, tbs_pkg::SumMax}) ? tbs_pkg::SumMax : sum_wide[SumW-1:0];
      good_d = (good_q == tbs_pkg::CountMax) ? good_q : good_q + 1'b1;
      for (int i = 0; i < tbs_pkg::NumBins; i++) begin
        if (int'(bin) == i && bin_q[i] != tbs_pkg::CountMax) begin
          bin_d[i] = bin_q[i] + 1'b1;
        end
      end
      if (!hit_q && s >= alert_lvl_q) begin
        hit_d     = 1'b1;
        hit_pos_d = (int'(pos_q) < int'(tbs_pkg::IndexMax)) ? IndexW'(pos_q)
                                                            : tbs_pkg::IndexMax;
        hit_val_d = s;
      end
    end
  end

  assign status_o.batch_end = last_i || (int'(pos_q) + 1 >= tbs_pkg::MaxBatch);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      sum_q     <= '0;
      min_q     <= '0;
      max_q     <= '0;
      good_q    <= '0;
      err_q     <= '0;
      hit_q     <= 1'b0;
      hit_pos_q <= '0;
      hit_val_q <= '0;
      for (int i = 0; i < tbs_pkg::NumBins; i++) begin
        bin_q[i] <= '0;
      end
    end else if (cmd_i.finish) begin
      pos_q     <= '0;
      sum_q     <= '0;
      min_q     <= '0;
      max_q     <= '0;
      good_q    <= '0;
      err_q     <= '0;
      hit_q     <= 1'b0;
      hit_pos_q <= '0;
      hit_val_q <= '0;
      for (int i = 0; i < tbs_pkg::NumBins; i++) begin
        bin_q[i] <= '0;
      end
    end else if (cmd_i.accept) begin
      pos_q     <= pos_d;
      sum_q     <= sum_d;
      min_q     <= min_d;
      max_q     <= max_d;
      good_q    <= good_d;
      err_q     <= err_d;
      hit_q     <= hit_d;
      hit_pos_q <= hit_pos_d;
      hit_val_q <= hit_val_d;
      for (int i = 0; i < tbs_pkg::NumBins; i++) begin
        bin_q[i] <= bin_d[i];
      end
    end
  end

  // batch snapshot and divider
  tbs_pkg::result_t  snap_q;
  logic              snap_hit_q;
  logic [SumW-1:0]   quot_q;
  logic [CountW-1:0] rem_q;
  logic [CountW-1:0] divisor_q;
  logic [CountW:0]   trial;
  logic [CountW:0]   trial_sub;
  logic              trial_ge;

  assign trial     = {rem_q, quot_q[SumW-1]};
  assign trial_ge  = trial >= {1'b0, divisor_q};
  assign trial_sub = trial - {1'b0, divisor_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      snap_q.minimum        <= min_d;
      snap_q.maximum        <= max_d;
      snap_q.average        <= '0;
      snap_q.valid_count    <= good_d;
      snap_q.skipped_count  <= err_d;
      snap_q.normal_count   <= bin_d[tbs_pkg::BIN_NORMAL];
      snap_q.warning_count  <= bin_d[tbs_pkg::BIN_WARNING];
      snap_q.critical_count <= bin_d[tbs_pkg::BIN_CRITICAL];
      snap_q.shutdown_count <= bin_d[tbs_pkg::BIN_SHUTDOWN];
      snap_q.alert_index    <= hit_pos_d;
      snap_q.alert_value    <= hit_val_d;
      snap_hit_q            <= hit_d;
      quot_q                <= sum_d;
      rem_q                 <= '0;
      divisor_q             <= good_d;
    end else if (cmd_i.div_step) begin
      quot_q <= {quot_q[SumW-2:0], trial_ge};
      rem_q  <= trial_ge ? trial_sub[CountW-1:0] : trial[CountW-1:0];
    end
  end

  // output register
  tbs_pkg::result_t out_d, out_q;
  logic             out_hit_q;

  always_comb begin
    out_d         = snap_q;
    out_d.average = (divisor_q == '0) ? '0 : quot_q[LevelW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q     <= out_d;
      out_hit_q <= snap_hit_q;
    end
  end

  assign result_o      = out_q;
  assign alert_found_o = out_hit_q;

endmodule

/* design/temperature_batch_statistics.sv */
// Temperature batch statistics, top level.
// Input stream: one 16-bit signed sample per word on s_axis, tlast marks the
// final sample of a batch; a batch also ends at its MaxBatch-th sample.
// Negative samples are counted as skipped; valid ones feed min, max, sum,
// four threshold bins and the first-alert latch.
// Output stream: one word per batch on m_axis with the statistics in tdata
// and the alert flag in tuser.
// Configuration: cfg_valid_i with cfg_index_i (0 warning, 1 critical,
// 2 shutdown, 3 alert) and cfg_data_i; cfg_ready_o is always high, other
// indexes are ignored. Write only while no batch is in progress.
// Throughput: one sample per cycle inside a batch.
// After the final sample is taken, the average comes from a restoring
// divider, one quotient bit a cycle over the 22-bit sum, then the result
// word is loaded into the output register; s_axis_tready stays low meanwhile.
// The result waits in an output register, so the next batch is taken while
// the receiver stalls; a second result waits in the divider until the first
// is taken, holding s_axis_tready low.
// Reset: thresholds return to 30, 40, 50 and 45 C, batch state is cleared.
`timescale 1ns / 1ps

module temperature_batch_statistics (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [tbs_pkg::SampleW-1:0]   s_axis_tdata,   // sample
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // minimum, maximum, average, valid_count, skipped_count, normal_count,
  // warning_count, critical_count, shutdown_count, alert_index, alert_value
  output logic [tbs_pkg::TdataW-1:0]    m_axis_tdata,
  output logic                          m_axis_tuser,   // alert_found
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tbs_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [tbs_pkg::LevelW-1:0]    cfg_data_i
);

  tbs_pkg::dp_cmd_t    cmd;
  tbs_pkg::dp_status_t status;
  tbs_pkg::result_t    result;

  tbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tbs_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .sample_i      (s_axis_tdata),
    .last_i        (s_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .result_o      (result),
    .alert_found_o (m_axis_tuser)
  );

  assign cfg_ready_o  = 1'b1;
  assign m_axis_tdata = {{(tbs_pkg::TdataW - tbs_pkg::ResW){1'b0}}, result};

endmodule

/* design/tbs_checker.sv */
// port-level checks for the temperature batch statistics block, with bind
// depends on tbs_pkg and temperature_batch_statistics
`timescale 1ns / 1ps

module tbs_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [tbs_pkg::TdataW-1:0]  m_axis_tdata,
  input logic                        m_axis_tuser
);

  tbs_pkg::result_t r;
  logic [tbs_pkg::CountW+1:0] bin_sum;

  assign r       = tbs_pkg::result_t'(m_axis_tdata[tbs_pkg::ResW-1:0]);
  assign bin_sum = (tbs_pkg::CountW+2)'(r.normal_count) + (tbs_pkg::CountW+2)'(r.warning_count)
                 + (tbs_pkg::CountW+2)'(r.critical_count)
                 + (tbs_pkg::CountW+2)'(r.shutdown_count);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                         && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  a_bins_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> bin_sum == (tbs_pkg::CountW+2)'(r.valid_count))
    else $error("bin counts do not add up to valid count");

  a_no_alert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> r.alert_index == '0 && r.alert_value == '0)
    else $error("alert fields set without alert");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && r.valid_count == '0 |->
      r.minimum == '0 && r.maximum == '0 && r.average == '0)
    else $error("empty batch with nonzero statistics");

  a_avg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && r.valid_count != '0 |->
      r.minimum <= r.average && r.average <= r.maximum)
    else $error("average outside min and max");

endmodule

bind temperature_batch_statistics tbs_checker u_tbs_checker (.*);
